@@ rtl/core/cbe_pkg.sv @@
// ----------------------------------------------------------------------------
// Contrast beta estimator package
// Widths, register indexes, state and command types shared by the core.
// ----------------------------------------------------------------------------
package cbe_pkg;

   localparam int MAX_WIDTH  = 4096;
   localparam int MAX_HEIGHT = 4096;

   localparam int PIXEL_W   = 24;
   localparam int CHAN_W    = 8;
   localparam int SQ_W      = 2 * CHAN_W;
   localparam int DIST_W    = SQ_W + 2;
   localparam int SUM_W     = 44;
   localparam int PAIRS_W   = 26;
   localparam int BETA_W    = 64;
   localparam int FRAC_W    = 32;
   localparam int QUO_W     = PAIRS_W + FRAC_W;
   localparam int DEN_W     = SUM_W + 1;
   localparam int DIV_CNT_W = $clog2(QUO_W);
   localparam int SIZE_W    = 13;
   localparam int X_W       = $clog2(MAX_WIDTH);
   localparam int Y_W       = $clog2(MAX_HEIGHT);
   localparam int PROD_W    = 2 * SIZE_W;
   localparam int PCALC_W   = PROD_W + 2;

   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = SIZE_W;

   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT = 1'b1;

   localparam logic [SIZE_W-1:0] WIDTH_RESET  = SIZE_W'(640);
   localparam logic [SIZE_W-1:0] HEIGHT_RESET = SIZE_W'(480);

   typedef enum logic [1:0] {
      NBR_LEFT,
      NBR_UPLEFT,
      NBR_UP,
      NBR_UPRIGHT
   } nbr_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_READ_UP,
      ST_READ_UR,
      ST_DIST,
      ST_UPDATE,
      ST_MUL,
      ST_PAIRS,
      ST_DIV_START,
      ST_DIV,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic    take;
      logic    rd_next;
      logic    cap_up;
      logic    dist_en;
      nbr_type nbr;
      logic    update;
      logic    mul;
      logic    pairs;
      logic    div_start;
      logic    load_out;
      logic    restart;
   } dp_cmd_type;

   typedef struct packed {
      logic last_pixel;
      logic out_free;
      logic div_done;
   } dp_status_type;

endpackage

@@ rtl/core/contrast_beta_estimator.sv @@
// ----------------------------------------------------------------------------
// Contrast beta estimator
// Takes RGB pixels of a frame in raster order and, after the last pixel,
// transfers one result: beta = pairs / (2 * sum) as unsigned 32.32 fixed
// point (zero when the sum is zero), the saturated sum of squared color
// distances to the left, up-left, up and up-right neighbors, and the pair
// count 4WH-3W-3H+2. Frame size comes from the image_width (index 0) and
// image_height (index 1) registers, clamped to 1..4096; a register write
// restarts the frame. Each pixel passes through the transfer, two reads
// of the row store (up and up-right), one pass per neighbor through the
// shared distance unit, and the update. The last pixel of a frame adds
// the pair-count multiply and subtract, the divider start, the bit-serial
// divider (58 quotient bits, then the done flag) and the result load, plus
// any wait for the previous result to be taken. The result sits in an
// output register, so a new pixel transfer is taken while the result
// waits. The row store is read on the first row of a frame too, but the
// up neighbors are masked out there, so entries never written do not
// reach the sum.
// ----------------------------------------------------------------------------
module contrast_beta_estimator (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [cbe_pkg::PIXEL_W-1:0]      req_pixel_rgb,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [cbe_pkg::BETA_W-1:0]       rsp_beta_value,
   output logic [cbe_pkg::SUM_W-1:0]        rsp_squared_sum,
   output logic [cbe_pkg::PAIRS_W-1:0]      rsp_neighbor_pairs,
   input  logic                             csr_we,
   input  logic [cbe_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [cbe_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import cbe_pkg::*;

   // Command and status between the sequencer and the datapath
   dp_cmd_type    cmd;
   dp_status_type status;

   // Sequencer: one pixel at a time, then the end-of-frame division
   cbe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Datapath: row store, neighbor registers, accumulator, divider and
   // the result register that holds until rsp_ready
   cbe_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .req_pixel_rgb      (req_pixel_rgb),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .rsp_ready          (rsp_ready),
      .rsp_valid          (rsp_valid),
      .rsp_beta_value     (rsp_beta_value),
      .rsp_squared_sum    (rsp_squared_sum),
      .rsp_neighbor_pairs (rsp_neighbor_pairs),
      .cmd                (cmd),
      .status             (status)
   );

endmodule

@@ rtl/core/cbe_div.sv @@
// ----------------------------------------------------------------------------
// Contrast beta estimator divider
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module cbe_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [cbe_pkg::QUO_W-1:0]   dividend,
   input  logic [cbe_pkg::DEN_W-1:0]   divisor,
   output logic                        done,
   output logic [cbe_pkg::QUO_W-1:0]   quotient
);
   import cbe_pkg::*;

   logic                 busy_ff;
   logic                 done_ff;
   logic [DIV_CNT_W-1:0] cnt_ff;
   logic [QUO_W-1:0]     quo_ff;
   logic [DEN_W-1:0]     rem_ff;
   logic [DEN_W-1:0]     den_ff;
   logic [DEN_W:0]       shifted;
   logic [DEN_W:0]       diff;
   logic                 qbit;
   logic [DEN_W-1:0]     rem_in;

   always_comb begin
      shifted = {rem_ff, quo_ff[QUO_W-1]};
      diff    = shifted - {1'b0, den_ff};
      qbit    = (shifted >= {1'b0, den_ff});
      rem_in  = qbit ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= DIV_CNT_W'(QUO_W - 1);
            quo_ff  <= dividend;
            rem_ff  <= '0;
            den_ff  <= divisor;
         end else if (busy_ff) begin
            rem_ff <= rem_in;
            quo_ff <= {quo_ff[QUO_W-2:0], qbit};
            cnt_ff <= cnt_ff - DIV_CNT_W'(1);
            if (cnt_ff == '0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

@@ rtl/core/cbe_datapath.sv @@
// ----------------------------------------------------------------------------
// Contrast beta estimator datapath
// Row store, neighbor registers, distance unit, accumulator, pair count,
// divider and result register.
// ----------------------------------------------------------------------------
module cbe_datapath (
   input  logic                             clock,
   input  logic                             reset,
   input  logic [cbe_pkg::PIXEL_W-1:0]      req_pixel_rgb,
   input  logic                             csr_we,
   input  logic [cbe_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [cbe_pkg::CSR_DATA_W-1:0]   csr_wdata,
   input  logic                             rsp_ready,
   output logic                             rsp_valid,
   output logic [cbe_pkg::BETA_W-1:0]       rsp_beta_value,
   output logic [cbe_pkg::SUM_W-1:0]        rsp_squared_sum,
   output logic [cbe_pkg::PAIRS_W-1:0]      rsp_neighbor_pairs,
   input  cbe_pkg::dp_cmd_type              cmd,
   output cbe_pkg::dp_status_type           status
);
   import cbe_pkg::*;

   function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                    input logic [SIZE_W-1:0] hi);
      logic [SIZE_W-1:0] r;
      if (v == '0) r = SIZE_W'(1);
      else if (v > hi) r = hi;
      else r = v;
      return r;
   endfunction

   function automatic logic [SQ_W-1:0] chan_sq(input logic [CHAN_W-1:0] a,
                                               input logic [CHAN_W-1:0] b);
      logic [SQ_W-1:0] d;
      d = SQ_W'((a > b) ? (a - b) : (b - a));
      return d * d;
   endfunction

   logic [PIXEL_W-1:0] row_mem [MAX_WIDTH];

   logic [SIZE_W-1:0]  width_ff, height_ff;
   logic [X_W-1:0]     col_ff;
   logic [Y_W-1:0]     row_ff;
   logic [PIXEL_W-1:0] pix_ff, left_ff, upleft_ff, up_ff, rd_data_ff;
   logic [DIST_W-1:0]  dist_ff;
   logic               dist_vld_ff;
   logic [SUM_W-1:0]   acc_ff;
   logic [PROD_W-1:0]  wh_ff;
   logic [PAIRS_W-1:0] pairs_ff;
   logic               rsp_valid_ff;
   logic [BETA_W-1:0]  beta_ff;
   logic [SUM_W-1:0]   sum_out_ff;
   logic [PAIRS_W-1:0] pairs_out_ff;

   logic [SIZE_W-1:0]  eff_w, eff_h, x_plus, y_plus;
   logic               has_right, has_below;
   logic [X_W-1:0]     rd_addr;
   logic [PIXEL_W-1:0] nbr_pix;
   logic               nbr_en;
   logic [DIST_W-1:0]  dist_in;
   logic [SUM_W:0]     acc_sum;
   logic [PCALC_W-1:0] pairs_calc;
   logic               div_done;
   logic [QUO_W-1:0]   quotient;

   always_comb begin
      eff_w     = clamp_size(width_ff, SIZE_W'(MAX_WIDTH));
      eff_h     = clamp_size(height_ff, SIZE_W'(MAX_HEIGHT));
      x_plus    = SIZE_W'(col_ff) + SIZE_W'(1);
      y_plus    = SIZE_W'(row_ff) + SIZE_W'(1);
      has_right = (x_plus < eff_w);
      has_below = (y_plus < eff_h);
      rd_addr   = cmd.rd_next ? x_plus[X_W-1:0] : col_ff;
   end

   // Neighbor select and squared color distance
   always_comb begin
      case (cmd.nbr)
         NBR_LEFT: begin
            nbr_pix = left_ff;
            nbr_en  = (col_ff != '0);
         end
         NBR_UPLEFT: begin
            nbr_pix = upleft_ff;
            nbr_en  = (col_ff != '0) && (row_ff != '0);
         end
         NBR_UP: begin
            nbr_pix = up_ff;
            nbr_en  = (row_ff != '0);
         end
         NBR_UPRIGHT: begin
            nbr_pix = rd_data_ff;
            nbr_en  = (row_ff != '0) && has_right;
         end
         default: begin
            nbr_pix = '0;
            nbr_en  = 1'b0;
         end
      endcase
      dist_in = DIST_W'(chan_sq(pix_ff[23:16], nbr_pix[23:16]))
              + DIST_W'(chan_sq(pix_ff[15:8], nbr_pix[15:8]))
              + DIST_W'(chan_sq(pix_ff[7:0], nbr_pix[7:0]));
      if (!nbr_en) dist_in = '0;
   end

   assign acc_sum    = {1'b0, acc_ff} + (SUM_W + 1)'(dist_ff);
   assign pairs_calc = {wh_ff, 2'b00} + PCALC_W'(2)
                     - (PCALC_W'({eff_w, 1'b0}) + PCALC_W'(eff_w))
                     - (PCALC_W'({eff_h, 1'b0}) + PCALC_W'(eff_h));

   always_ff @(posedge clock) begin
      rd_data_ff <= row_mem[rd_addr];
      if (cmd.update) row_mem[col_ff] <= pix_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff     <= WIDTH_RESET;
         height_ff    <= HEIGHT_RESET;
         col_ff       <= '0;
         row_ff       <= '0;
         left_ff      <= '0;
         upleft_ff    <= '0;
         acc_ff       <= '0;
         dist_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         dist_vld_ff <= cmd.dist_en;
         if (dist_vld_ff) acc_ff <= acc_sum[SUM_W] ? '1 : acc_sum[SUM_W-1:0];
         if (cmd.update) begin
            upleft_ff <= (row_ff != '0) ? up_ff : '0;
            left_ff   <= pix_ff;
            if (has_right) begin
               col_ff <= x_plus[X_W-1:0];
            end else begin
               col_ff <= '0;
               row_ff <= has_below ? y_plus[Y_W-1:0] : '0;
            end
         end
         if (cmd.load_out) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
         // restart the frame on a register write or after the result
         if (cmd.restart || csr_we) begin
            col_ff    <= '0;
            row_ff    <= '0;
            left_ff   <= '0;
            upleft_ff <= '0;
            acc_ff    <= '0;
         end
         if (csr_we) begin
            case (csr_index)
               CSR_IMAGE_WIDTH:  width_ff  <= csr_wdata;
               CSR_IMAGE_HEIGHT: height_ff <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.take) pix_ff <= req_pixel_rgb;
      if (cmd.cap_up) up_ff <= rd_data_ff;
      if (cmd.dist_en) dist_ff <= dist_in;
      if (cmd.mul) wh_ff <= PROD_W'(eff_w) * PROD_W'(eff_h);
      if (cmd.pairs) pairs_ff <= pairs_calc[PAIRS_W-1:0];
      if (cmd.load_out) begin
         beta_ff      <= (acc_ff == '0) ? '0 : BETA_W'(quotient);
         sum_out_ff   <= acc_ff;
         pairs_out_ff <= pairs_ff;
      end
   end

   cbe_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend ({pairs_ff, FRAC_W'(0)}),
      .divisor  ({acc_ff, 1'b0}),
      .done     (div_done),
      .quotient (quotient)
   );

   always_comb begin
      status.last_pixel = !has_right && !has_below;
      status.out_free   = !rsp_valid_ff || rsp_ready;
      status.div_done   = div_done;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_beta_value     = beta_ff;
   assign rsp_squared_sum    = sum_out_ff;
   assign rsp_neighbor_pairs = pairs_out_ff;

   a_acc_monotone: assert property (@(posedge clock) disable iff (reset)
      (!cmd.restart && !csr_we) |=> (acc_ff >= $past(acc_ff)))
      else $error("accumulator decreased without a frame restart");

   a_coord_in_frame: assert property (@(posedge clock) disable iff (reset)
      (SIZE_W'(col_ff) < eff_w) && (SIZE_W'(row_ff) < eff_h))
      else $error("pixel coordinate outside the frame");

   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> (!rsp_valid_ff || rsp_ready))
      else $error("result register overwritten while full");

   a_div_at_frame_end: assert property (@(posedge clock) disable iff (reset)
      cmd.div_start |-> (col_ff == '0) && (row_ff == '0))
      else $error("division started before the frame wrapped");

endmodule

@@ rtl/core/cbe_ctrl.sv @@
// ----------------------------------------------------------------------------
// Contrast beta estimator controller
// Sequences row-store reads, the four neighbor distances, the update and
// the end-of-frame division.
// ----------------------------------------------------------------------------
module cbe_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  cbe_pkg::dp_status_type    status,
   output cbe_pkg::dp_cmd_type       cmd
);
   import cbe_pkg::*;

   state_type state_ff, state_in;
   nbr_type   nbr_ff, nbr_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         nbr_ff   <= NBR_LEFT;
      end else begin
         state_ff <= state_in;
         nbr_ff   <= nbr_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      nbr_in    = nbr_ff;
      cmd       = '0;
      cmd.nbr   = nbr_ff;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.take = 1'b1;
               state_in = ST_READ_UP;
            end
         end
         ST_READ_UP: begin
            state_in = ST_READ_UR;
         end
         ST_READ_UR: begin
            cmd.rd_next = 1'b1;
            cmd.cap_up  = 1'b1;
            nbr_in      = NBR_LEFT;
            state_in    = ST_DIST;
         end
         ST_DIST: begin
            cmd.rd_next = 1'b1;
            cmd.dist_en = 1'b1;
            if (nbr_ff == NBR_UPRIGHT) begin
               nbr_in   = NBR_LEFT;
               state_in = ST_UPDATE;
            end else begin
               nbr_in = nbr_type'(2'(nbr_ff) + 2'd1);
            end
         end
         ST_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = status.last_pixel ? ST_MUL : ST_IDLE;
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_PAIRS;
         end
         ST_PAIRS: begin
            cmd.pairs = 1'b1;
            state_in  = ST_DIV_START;
         end
         ST_DIV_START: begin
            cmd.div_start = 1'b1;
            state_in      = ST_DIV;
         end
         ST_DIV: begin
            if (status.div_done) state_in = ST_OUT;
         end
         ST_OUT: begin
            if (status.out_free) begin
               cmd.load_out = 1'b1;
               cmd.restart  = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

@@ tb/contrast_beta_estimator_tb.sv @@
// ----------------------------------------------------------------------------
// Contrast beta estimator testbench
// Streams RGB frames through the pixel channel and checks every frame result
// (beta, squared distance sum, pair count) against an in-bench estimate of
// the same frame. A short table of directed rows comes first: reset sizes,
// 1x1 and flat frames, clamped sizes and a restart in the middle of a frame.
// Random frames follow: small sizes with random, flat, noisy and saturated
// colors, a few frame prefixes at clamped largest sizes, aborted frames, a
// long result back-pressure stretch and random idle cycles on both channels.
// ----------------------------------------------------------------------------
module contrast_beta_estimator_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import cbe_pkg::*;

   localparam int CLK_PERIOD      = 10;
   localparam int RESET_CYCLES    = 10;
   localparam int SETTLE_CYCLES   = 16;    // lets the last pixel finish inside the block
   localparam int DRAIN_CYCLES    = 100;   // lets the divider tail finish
   localparam int WATCHDOG_LIMIT  = 3000;
   localparam int HOLD_OFF_CYCLES = 600;
   localparam int PRESSURE_PIXELS = 12;
   localparam int RANDOM_ITEMS    = 850;
   localparam int MIN_FRAMES      = 48;
   localparam int PRESSURE_FRAME  = 5;
   localparam int WIDE_FRAME      = 12;
   localparam int TALL_FRAME      = 24;
   localparam int LINE_FRAME      = 36;
   localparam int BIG_PREFIX      = 48;   // pixels sent into a large frame

   typedef struct packed {
      logic [BETA_W-1:0]  beta_value;
      logic [SUM_W-1:0]   squared_sum;
      logic [PAIRS_W-1:0] neighbor_pairs;
   } beta_result_type;

   typedef enum logic [1:0] {
      ROW_PIXEL,
      ROW_WIDTH,
      ROW_HEIGHT
   } row_kind_type;

   typedef struct packed {
      row_kind_type       kind;
      logic [PIXEL_W-1:0] value;     // pixel, or register value in the low bits
      logic               typed;     // result below replaces the estimate
      beta_result_type    result;
   } stim_row_type;

   typedef enum int {
      FILL_RANDOM,
      FILL_FLAT,
      FILL_NOISY,
      FILL_EXTREME
   } fill_style_type;

   localparam beta_result_type NOT_TYPED  = '0;
   localparam beta_result_type ZERO_FRAME = '0;
   localparam beta_result_type FLAT_2X2   =
      '{beta_value: '0, squared_sum: '0, neighbor_pairs: 26'd6};

   localparam int DIRECTED_ROWS = 27;

   // Directed rows. Frames that end with a typed row have a result that is
   // plain from the frame itself: single pixels and flat images give a zero
   // sum and so a zero beta.
   stim_row_type directed_table [DIRECTED_ROWS] = '{
      // two pixels into the 640x480 reset frame, then restart it by a write
      '{ROW_PIXEL,  24'hFFFFFF, 1'b0, NOT_TYPED},
      '{ROW_PIXEL,  24'h000000, 1'b0, NOT_TYPED},
      '{ROW_WIDTH,  24'd1,      1'b0, NOT_TYPED},
      '{ROW_HEIGHT, 24'd1,      1'b0, NOT_TYPED},
      // 1x1 frames: no neighbors, no pairs
      '{ROW_PIXEL,  24'hFFFFFF, 1'b1, ZERO_FRAME},
      '{ROW_PIXEL,  24'h000000, 1'b1, ZERO_FRAME},
      // zero sizes clamp up to 1x1
      '{ROW_WIDTH,  24'd0,      1'b0, NOT_TYPED},
      '{ROW_HEIGHT, 24'd0,      1'b0, NOT_TYPED},
      '{ROW_PIXEL,  24'h123456, 1'b1, ZERO_FRAME},
      // 2x1: one pair at full color distance
      '{ROW_WIDTH,  24'd2,      1'b0, NOT_TYPED},
      '{ROW_PIXEL,  24'h000000, 1'b0, NOT_TYPED},
      '{ROW_PIXEL,  24'hFFFFFF, 1'b0, NOT_TYPED},
      // 2x2 flat image
      '{ROW_HEIGHT, 24'd2,      1'b0, NOT_TYPED},
      '{ROW_PIXEL,  24'h808080, 1'b0, NOT_TYPED},
      '{ROW_PIXEL,  24'h808080, 1'b0, NOT_TYPED},
      '{ROW_PIXEL,  24'h808080, 1'b0, NOT_TYPED},
      '{ROW_PIXEL,  24'h808080, 1'b1, FLAT_2X2},
      // 3x2 with primaries and extremes in every neighbor direction
      '{ROW_WIDTH,  24'd3,      1'b0, NOT_TYPED},
      '{ROW_PIXEL,  24'hFF0000, 1'b0, NOT_TYPED},
      '{ROW_PIXEL,  24'h00FF00, 1'b0, NOT_TYPED},
      '{ROW_PIXEL,  24'h0000FF, 1'b0, NOT_TYPED},
      '{ROW_PIXEL,  24'hFFFFFF, 1'b0, NOT_TYPED},
      '{ROW_PIXEL,  24'h000000, 1'b0, NOT_TYPED},
      '{ROW_PIXEL,  24'hAA55AA, 1'b0, NOT_TYPED},
      // start a 3x3 frame and leave it open; the random part restarts it
      '{ROW_HEIGHT, 24'd3,      1'b0, NOT_TYPED},
      '{ROW_PIXEL,  24'h0F0F0F, 1'b0, NOT_TYPED},
      '{ROW_PIXEL,  24'hF0F0F0, 1'b0, NOT_TYPED}
   };

   // DUT connections; every input starts at a known value
   logic                  clock         = 1'b0;
   logic                  reset         = 1'b1;
   logic                  req_valid     = 1'b0;
   logic                  req_ready;
   logic [PIXEL_W-1:0]    req_pixel_rgb = '0;
   logic                  rsp_valid;
   logic                  rsp_ready     = 1'b0;
   logic [BETA_W-1:0]     rsp_beta_value;
   logic [SUM_W-1:0]      rsp_squared_sum;
   logic [PAIRS_W-1:0]    rsp_neighbor_pairs;
   logic                  csr_we        = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index     = CSR_IMAGE_WIDTH;
   logic [CSR_DATA_W-1:0] csr_wdata     = '0;

   // Frame estimate state: previous row, neighbor pixels, raster position
   logic [PIXEL_W-1:0] prev_row [MAX_WIDTH];
   logic [PIXEL_W-1:0] left_px;
   logic [PIXEL_W-1:0] upleft_px;
   int unsigned        col_pos;
   int unsigned        row_pos;
   logic [SUM_W-1:0]   dist_acc;
   logic [SIZE_W-1:0]  width_reg;
   logic [SIZE_W-1:0]  height_reg;

   beta_result_type pending_betas [$];   // frame results still owed by the block
   int              frames_closed  = 0;
   int              mismatch_count = 0;
   int              idle_cycles    = 0;
   bit              hold_request   = 1'b0;   // ask the result side for a long hold-off

   contrast_beta_estimator u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_pixel_rgb      (req_pixel_rgb),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_beta_value     (rsp_beta_value),
      .rsp_squared_sum    (rsp_squared_sum),
      .rsp_neighbor_pairs (rsp_neighbor_pairs),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // ---------------------------------------------------------------------
   // Frame estimate
   // ---------------------------------------------------------------------

   // Clamp a size register into 1..limit.
   function automatic int unsigned clamp_size(input logic [SIZE_W-1:0] size_value,
                                              input int unsigned limit);
      if (size_value == 0) return 1;
      if (size_value > limit) return limit;
      return size_value;
   endfunction

   // Sum over R, G and B of the squared channel differences.
   function automatic logic [DIST_W-1:0] rgb_distance(input logic [PIXEL_W-1:0] a,
                                                      input logic [PIXEL_W-1:0] b);
      logic [DIST_W-1:0] total;
      int                ca;
      int                cb;
      total = '0;
      for (int c = 0; c < 3; c++) begin
         ca = a[CHAN_W*c +: CHAN_W];
         cb = b[CHAN_W*c +: CHAN_W];
         total += DIST_W'((ca - cb) * (ca - cb));
      end
      return total;
   endfunction

   // Add into the frame total, saturating at the top of the accumulator.
   function automatic void add_distance(input logic [DIST_W-1:0] distance_in);
      logic [SUM_W:0] total;
      total    = {1'b0, dist_acc} + (SUM_W + 1)'(distance_in);
      dist_acc = total[SUM_W] ? '1 : total[SUM_W-1:0];
   endfunction

   function automatic void clear_frame_state();
      left_px   = '0;
      upleft_px = '0;
      col_pos   = 0;
      row_pos   = 0;
      dist_acc  = '0;
   endfunction

   // Advance the estimate by one pixel; return 1 with the frame result when
   // the pixel closes the frame.
   function automatic bit estimate_pixel(input logic [PIXEL_W-1:0] pixel,
                                         output beta_result_type result);
      int unsigned        w;
      int unsigned        h;
      int unsigned        x;
      int unsigned        y;
      logic [PIXEL_W-1:0] up_px;
      logic [63:0]        w_ext;
      logic [63:0]        h_ext;
      logic [63:0]        pairs;
      logic [127:0]       quotient;
      w      = clamp_size(width_reg, MAX_WIDTH);
      h      = clamp_size(height_reg, MAX_HEIGHT);
      x      = (col_pos >= w) ? w - 1 : col_pos;
      y      = (row_pos >= h) ? h - 1 : row_pos;
      up_px  = '0;
      result = '0;

      if (x > 0) add_distance(rgb_distance(pixel, left_px));
      if (y > 0) begin
         up_px = prev_row[x];
         if (x > 0) add_distance(rgb_distance(pixel, upleft_px));
         add_distance(rgb_distance(pixel, up_px));
         if (x + 1 < w) add_distance(rgb_distance(pixel, prev_row[x + 1]));
      end

      // the up pixel of this column is the up-left pixel of the next one
      upleft_px   = (y > 0) ? up_px : '0;
      prev_row[x] = pixel;
      left_px     = pixel;

      if (x + 1 < w) begin
         col_pos = x + 1;
         row_pos = y;
         return 1'b0;
      end
      col_pos = 0;
      if (y + 1 < h) begin
         row_pos = y + 1;
         return 1'b0;
      end

      // last pixel: beta = pairs / (2 * sum) in 32.32, floor, saturating
      w_ext = w;
      h_ext = h;
      pairs = 4 * w_ext * h_ext + 2 - 3 * w_ext - 3 * h_ext;
      if (dist_acc != 0) begin
         quotient = {pairs, 32'b0} / {dist_acc, 1'b0};
         result.beta_value = (quotient >> BETA_W) != 0 ? '1 : quotient[BETA_W-1:0];
      end
      result.squared_sum    = dist_acc;
      result.neighbor_pairs = pairs[PAIRS_W-1:0];
      clear_frame_state();
      return 1'b1;
   endfunction

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------

   function automatic logic [PIXEL_W-1:0] make_pixel(input fill_style_type style,
                                                     input logic [PIXEL_W-1:0] base);
      logic [PIXEL_W-1:0] pixel;
      pixel = base;
      for (int c = 0; c < 3; c++) begin
         case (style)
            FILL_RANDOM:  pixel[CHAN_W*c +: CHAN_W] = CHAN_W'($urandom);
            FILL_NOISY:   pixel[CHAN_W*c +: CHAN_W] =
                             base[CHAN_W*c +: CHAN_W] + CHAN_W'($urandom_range(0, 6)) - 8'd3;
            FILL_EXTREME: pixel[CHAN_W*c +: CHAN_W] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            default:      pixel[CHAN_W*c +: CHAN_W] = base[CHAN_W*c +: CHAN_W];
         endcase
      end
      return pixel;
   endfunction

   // Offer one pixel after an idle gap and hold it until the transfer; then
   // advance the estimate and queue the frame result if the pixel closes it.
   task automatic send_pixel(input logic [PIXEL_W-1:0] pixel, input int gap,
                             input logic use_typed, input beta_result_type typed_result);
      beta_result_type estimate;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_pixel_rgb <= pixel;
      do @(posedge clock); while (!req_ready);
      if (estimate_pixel(pixel, estimate)) begin
         if (use_typed) estimate = typed_result;
         pending_betas = {pending_betas, estimate};
         frames_closed++;
      end
   endtask

   // Write a size register with the block idle: drop valid, drain every
   // owed result, let the last pixel finish, then one write cycle.
   task automatic write_register(input logic [CSR_IDX_W-1:0] index,
                                 input logic [SIZE_W-1:0] value);
      req_valid <= 1'b0;
      while (pending_betas.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      if (index == CSR_IMAGE_WIDTH) width_reg = value;
      else height_reg = value;
      // any write restarts the frame
      clear_frame_state();
   endtask

   task automatic resize_frame(input logic [SIZE_W-1:0] w, input logic [SIZE_W-1:0] h);
      write_register(CSR_IMAGE_WIDTH, w);
      write_register(CSR_IMAGE_HEIGHT, h);
   endtask

   task automatic flag_mismatch(input string msg);
      $display("ERROR at %0t ns: %s", $time, msg);
      mismatch_count++;
   endtask

   // ---------------------------------------------------------------------
   // Result side: random stalls per result, one long hold-off on request
   // ---------------------------------------------------------------------
   initial begin : result_side
      int stall_cycles;
      wait (reset == 1'b0);
      @(posedge clock);
      forever begin
         if (hold_request)
            stall_cycles = HOLD_OFF_CYCLES;
         else if ($urandom_range(0, 3) == 0)
            stall_cycles = 0;
         else
            stall_cycles = $urandom_range(0, 16);
         hold_request = 1'b0;
         if (stall_cycles > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall_cycles) @(posedge clock);
         end
         // keep ready high across back-to-back transfers
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   // Compare each result transfer with the oldest owed frame result.
   always @(posedge clock) begin : result_check
      beta_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_betas.size() == 0) begin
            flag_mismatch($sformatf("result with no frame closed: beta %0h sum %0h pairs %0h",
                                    rsp_beta_value, rsp_squared_sum, rsp_neighbor_pairs));
         end else begin
            want = pending_betas.pop_front();
            if (rsp_beta_value !== want.beta_value)
               flag_mismatch($sformatf("beta_value got %0h expected %0h",
                                       rsp_beta_value, want.beta_value));
            if (rsp_squared_sum !== want.squared_sum)
               flag_mismatch($sformatf("squared_sum got %0h expected %0h",
                                       rsp_squared_sum, want.squared_sum));
            if (rsp_neighbor_pairs !== want.neighbor_pairs)
               flag_mismatch($sformatf("neighbor_pairs got %0h expected %0h",
                                       rsp_neighbor_pairs, want.neighbor_pairs));
         end
      end
   end

   // Watchdog: count cycles without any transfer on either channel.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // ---------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------
   initial begin : stimulus
      int                 frame_no;
      int                 small_pixels;
      int unsigned        frame_pixels;
      int unsigned        send_count;
      bit                 force_resize;
      bit                 big_frame;
      bit                 quiet;
      bit                 abort;
      int                 pick;
      fill_style_type     style;
      logic [PIXEL_W-1:0] base;

      frame_no     = 0;
      small_pixels = 0;
      force_resize = 1'b1;   // the directed part leaves a frame open
      width_reg    = WIDTH_RESET;
      height_reg   = HEIGHT_RESET;
      clear_frame_state();

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // walk the directed table
      foreach (directed_table[r]) begin
         case (directed_table[r].kind)
            ROW_WIDTH: begin
               write_register(CSR_IMAGE_WIDTH, directed_table[r].value[SIZE_W-1:0]);
            end
            ROW_HEIGHT: begin
               write_register(CSR_IMAGE_HEIGHT, directed_table[r].value[SIZE_W-1:0]);
            end
            default: begin
               send_pixel(directed_table[r].value, $urandom_range(0, 16),
                          directed_table[r].typed, directed_table[r].result);
            end
         endcase
      end

      // random frames
      while (small_pixels < RANDOM_ITEMS || frames_closed < MIN_FRAMES) begin
         frame_no++;
         if (frame_no == PRESSURE_FRAME) begin
            // 1x1 frames back to back while the result side holds off:
            // fill the output register and stall the pixel input
            resize_frame(SIZE_W'(1), SIZE_W'(1));
            hold_request = 1'b1;
            repeat (PRESSURE_PIXELS) send_pixel(PIXEL_W'($urandom), 0, 1'b0, NOT_TYPED);
            force_resize = 1'b1;
         end else begin
            big_frame = 1'b1;
            case (frame_no)
               WIDE_FRAME: resize_frame(13'h1FFF, SIZE_W'(2));   // width clamps to 4096
               TALL_FRAME: resize_frame(SIZE_W'(1), 13'h1FFF);   // height clamps to 4096
               LINE_FRAME: resize_frame(SIZE_W'(4096), SIZE_W'(1));
               default: begin
                  big_frame = 1'b0;
                  pick      = $urandom_range(0, 3);
                  if (force_resize || pick == 3 || pick == 1) begin
                     write_register(CSR_IMAGE_WIDTH, SIZE_W'(
                        ($urandom_range(0, 9) == 0) ? 0 :
                        ($urandom_range(0, 7) == 0) ? $urandom_range(9, 24) :
                                                      $urandom_range(1, 8)));
                  end
                  if (force_resize || pick == 3 || pick == 2) begin
                     write_register(CSR_IMAGE_HEIGHT, SIZE_W'(
                        ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 5)));
                  end
               end
            endcase

            style        = fill_style_type'($urandom_range(0, 3));
            base         = PIXEL_W'($urandom);
            quiet        = big_frame || ($urandom_range(0, 3) == 0);
            frame_pixels = clamp_size(width_reg, MAX_WIDTH) * clamp_size(height_reg, MAX_HEIGHT);
            send_count   = frame_pixels;
            abort        = frame_pixels > 1 && ($urandom_range(0, 9) == 0);
            if (abort) send_count = $urandom_range(0, frame_pixels - 1);
            // large frames: send only the first BIG_PREFIX pixels
            if (big_frame) begin
               abort      = 1'b1;
               send_count = BIG_PREFIX;
            end

            for (int i = 0; i < send_count; i++)
               send_pixel(make_pixel(style, base), quiet ? 0 : $urandom_range(0, 16),
                          1'b0, NOT_TYPED);
            small_pixels += send_count;

            // cut a frame short: rewrite a register to restart it
            if (abort) write_register(CSR_IMAGE_HEIGHT, height_reg);
            force_resize = big_frame;
         end
      end

      // drain owed results, then let the block go quiet
      req_valid <= 1'b0;
      while (pending_betas.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
